### rtl/smds_pkg.sv
// Package: shared types and codes for the two-stack shared-memory block.
package smds_pkg;

   // Payload field widths
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH_ONE = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_TWO = 2'd1;
   localparam logic [OP_W-1:0] OP_POP_ONE  = 2'd2;
   localparam logic [OP_W-1:0] OP_POP_TWO  = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;    // item taken this cycle: update counters, store, result
      logic load_ram;  // capture popped word from the RAM read port
   } smds_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic pop_ok;    // offered item is a pop on a non-empty stack
   } smds_stat_type;

endpackage

### rtl/smds_if.sv
// Interfaces: request and response handshake channels.
interface smds_req_if
   import smds_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [VALUE_W-1:0] push_value;

   modport source (output valid, op, push_value, input ready);
   modport sink   (input valid, op, push_value, output ready);
endinterface

interface smds_rsp_if
   import smds_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  pop_value;
   logic [STATUS_W-1:0] status;
   logic [USED_W-1:0]   used_count;

   modport source (output valid, pop_value, status, used_count, input ready);
   modport sink   (input valid, pop_value, status, used_count, output ready);
endinterface

### rtl/smds_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/smds_datapath.sv
// Datapath: stack counters, word store, address generation and result registers.
module smds_datapath
   import smds_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [OP_W-1:0]     req_op,
   input  logic [VALUE_W-1:0]  req_push_value,
   input  smds_cmd_type        cmd,
   output smds_stat_type       stat,
   output logic [VALUE_W-1:0]  rsp_pop_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [USED_W-1:0]   rsp_used_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = (CNT_W + 1 > USED_W) ? CNT_W + 1 : USED_W;

   logic [CNT_W-1:0]    lower_ff, lower_in;
   logic [CNT_W-1:0]    upper_ff, upper_in;
   logic [VALUE_W-1:0]  pop_value_ff, pop_value_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [USED_W-1:0]   used_ff, used_in;

   logic [SUM_W-1:0]    sum_now;
   logic [SUM_W-1:0]    sum_next;
   logic                full;
   logic                status_ok;
   logic [STATUS_W-1:0] status_cur;
   logic [CNT_W-1:0]    addr_wide;
   logic [AW-1:0]       mem_addr;
   logic                mem_wr;
   logic                mem_rd;
   logic [VALUE_W-1:0]  mem_rdata;

   // Occupancy and full flag
   assign sum_now = SUM_W'(lower_ff) + SUM_W'(upper_ff);
   assign full    = (sum_now >= SUM_W'(DEPTH));

   // Decode the offered item: outcome, address and counter updates
   always_comb begin
      status_cur = STATUS_DONE;
      addr_wide  = '0;
      lower_in   = lower_ff;
      upper_in   = upper_ff;
      case (req_op)
         OP_PUSH_ONE: begin
            addr_wide = lower_ff;
            if (full) begin
               status_cur = STATUS_FULL;
            end else begin
               lower_in = lower_ff + CNT_W'(1);
            end
         end
         OP_PUSH_TWO: begin
            addr_wide = CNT_W'(DEPTH - 1) - upper_ff;
            if (full) begin
               status_cur = STATUS_FULL;
            end else begin
               upper_in = upper_ff + CNT_W'(1);
            end
         end
         OP_POP_ONE: begin
            addr_wide = lower_ff - CNT_W'(1);
            if (lower_ff == '0) begin
               status_cur = STATUS_EMPTY;
            end else begin
               lower_in = lower_ff - CNT_W'(1);
            end
         end
         default: begin
            addr_wide = CNT_W'(DEPTH) - upper_ff;
            if (upper_ff == '0) begin
               status_cur = STATUS_EMPTY;
            end else begin
               upper_in = upper_ff - CNT_W'(1);
            end
         end
      endcase
   end

   assign status_ok   = (status_cur == STATUS_DONE);
   assign stat.pop_ok = status_ok && (req_op inside {OP_POP_ONE, OP_POP_TWO});
   assign mem_addr    = addr_wide[AW-1:0];
   assign mem_wr      = cmd.accept && status_ok && (req_op inside {OP_PUSH_ONE, OP_PUSH_TWO});
   assign mem_rd      = cmd.accept && stat.pop_ok;
   assign sum_next    = SUM_W'(lower_in) + SUM_W'(upper_in);

   // Word store
   smds_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data (req_push_value),
      .rd_en   (mem_rd),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   // Next values of the result registers
   always_comb begin
      pop_value_in = pop_value_ff;
      status_in    = status_ff;
      used_in      = used_ff;
      if (cmd.accept) begin
         pop_value_in = '0;
         status_in    = status_cur;
         used_in      = sum_next[USED_W-1:0];
      end else if (cmd.load_ram) begin
         pop_value_in = mem_rdata;
      end
   end

   // Counters: advance on accepted items only
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
      end else if (cmd.accept) begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      pop_value_ff <= pop_value_in;
      status_ff    <= status_in;
      used_ff      <= used_in;
   end

   assign rsp_pop_value  = pop_value_ff;
   assign rsp_status     = status_ff;
   assign rsp_used_count = used_ff;

   // The two stacks never hold more than the memory
   assert property (@(posedge clock) disable iff (reset)
      sum_now <= SUM_W'(DEPTH))
      else $error("stack counters exceed memory depth");

   // A failed item leaves both counters unchanged
   assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !status_ok) |=>
         (lower_ff == $past(lower_ff)) && (upper_ff == $past(upper_ff)))
      else $error("failed item changed a stack counter");

   // Load of popped word only comes the cycle after an accepted pop
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_ram |-> $past(mem_rd))
      else $error("popped word captured without a read");

endmodule

### rtl/smds_ctrl.sv
// Controller: handshake control and sequencing of the memory read on a pop.
module smds_ctrl
   import smds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  smds_stat_type stat,
   output smds_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   // Take an item when idle and the result register is free or draining
   assign req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept       = req_valid && req_ready;
   assign cmd.accept   = accept;
   assign cmd.load_ram = (state_ff == ST_READ);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && stat.pop_ok) begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set when the payload is complete, drop on hand-off
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((accept && !stat.pop_ok) || (state_ff == ST_READ)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // While the read is outstanding the result register is empty
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("result pending during memory read");

   // A read returns to idle and presents its result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("pop result not presented after read");

   // An accepted push or failed item sets the result valid register
   assert property (@(posedge clock) disable iff (reset)
      (accept && !stat.pop_ok) |=> rsp_valid_ff)
      else $error("result missing after accepted item");

endmodule

### rtl/shared_memory_double_stack_top.sv
// Top level: two LIFO stacks sharing one word memory, growing from opposite ends.
// A push or failed item has its result registered on acceptance; a successful pop
// has it registered only after the RAM's registered read, in the read state.
// Pushes and failed items are taken one item per cycle; a successful pop holds off
// input during its read; a result waiting in the output register stalls input.
// Reset clears both stack counters and the result valid; the memory is not cleared.
module shared_memory_double_stack_top
   import smds_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   smds_req_if.sink    req_chan,
   smds_rsp_if.source  rsp_chan
);

   smds_cmd_type  cmd;
   smds_stat_type stat;

   // Sequencing and handshakes
   smds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Counters, memory and result payload
   smds_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_chan.op),
      .req_push_value (req_chan.push_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_pop_value  (rsp_chan.pop_value),
      .rsp_status     (rsp_chan.status),
      .rsp_used_count (rsp_chan.used_count)
   );

endmodule
